// ----- rtl/tfnb_pkg.sv -----
// Package: payload types, constants and helpers for the triangle normal block.
package tfnb_pkg;

    localparam int COORD_BITS_DEF       = 32;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam logic [22:0] TRI_LIMIT   = 23'd5000000;
    localparam logic signed [31:0] CORNER_EMPTY_LOW  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CORNER_EMPTY_HIGH = 32'sh8000_0000;
    localparam logic signed [15:0] NORMAL_MAX = 16'sd32767;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic               flip;
    } tri_in_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
        logic               swapped;
        logic [22:0]        triangle_total;
        logic signed [31:0] low_x;
        logic signed [31:0] low_y;
        logic signed [31:0] low_z;
        logic signed [31:0] high_x;
        logic signed [31:0] high_y;
        logic signed [31:0] high_z;
    } tri_out_t;

    // Front-to-back queue entry: edge vectors plus bookkeeping already done.
    typedef struct packed {
        logic signed [32:0] u_x;
        logic signed [32:0] u_y;
        logic signed [32:0] u_z;
        logic signed [32:0] v_x;
        logic signed [32:0] v_y;
        logic signed [32:0] v_z;
        logic               flip;
        logic [22:0]        total;
        logic signed [31:0] low_x;
        logic signed [31:0] low_y;
        logic signed [31:0] low_z;
        logic signed [31:0] high_x;
        logic signed [31:0] high_y;
        logic signed [31:0] high_z;
    } tri_job_t;

endpackage

// ----- rtl/tfnb_front.sv -----
// Front end: vertex swap, edge vectors, running bounds and triangle count.
module tfnb_front
    import tfnb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tri_in_t  in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output tri_job_t job_data
);

    logic signed [31:0] min_reg [3];
    logic signed [31:0] max_reg [3];
    logic [22:0]        cnt_reg;
    logic               job_valid_reg;
    tri_job_t           job_reg;

    logic signed [31:0] a [3], b [3], c [3];
    logic signed [31:0] lo_next [3], hi_next [3];
    logic signed [32:0] u [3], v [3];
    logic [22:0]        cnt_next;

    function automatic logic signed [31:0] sx(input logic [31:0] x);
        logic [31:0] r;
        r = x;
        for (int k = COORD_BITS; k < 32; k++)
            r[k] = x[COORD_BITS-1];
        return $signed(r);
    endfunction

    assign in_ready = !job_valid_reg || job_ready;

    always_comb
    begin
        logic signed [31:0] lo, hi, bv, cv;
        a[0] = sx(in_data.a_x); a[1] = sx(in_data.a_y); a[2] = sx(in_data.a_z);
        b[0] = sx(in_data.b_x); b[1] = sx(in_data.b_y); b[2] = sx(in_data.b_z);
        c[0] = sx(in_data.c_x); c[1] = sx(in_data.c_y); c[2] = sx(in_data.c_z);
        for (int i = 0; i < 3; i++)
        begin
            bv = in_data.flip ? c[i] : b[i];
            cv = in_data.flip ? b[i] : c[i];
            u[i] = 33'(bv) - 33'(a[i]);
            v[i] = 33'(cv) - 33'(a[i]);
            lo = a[i];
            hi = a[i];
            if (b[i] < lo) lo = b[i];
            if (c[i] < lo) lo = c[i];
            if (b[i] > hi) hi = b[i];
            if (c[i] > hi) hi = c[i];
            lo_next[i] = (lo < min_reg[i]) ? lo : min_reg[i];
            hi_next[i] = (hi > max_reg[i]) ? hi : max_reg[i];
        end
        cnt_next = (cnt_reg < TRI_LIMIT) ? cnt_reg + 23'd1 : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            job_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= CORNER_EMPTY_LOW;
                max_reg[i] <= CORNER_EMPTY_HIGH;
            end
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                job_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
                for (int i = 0; i < 3; i++)
                begin
                    min_reg[i] <= lo_next[i];
                    max_reg[i] <= hi_next[i];
                end
                job_reg.u_x <= u[0]; job_reg.u_y <= u[1]; job_reg.u_z <= u[2];
                job_reg.v_x <= v[0]; job_reg.v_y <= v[1]; job_reg.v_z <= v[2];
                job_reg.flip  <= in_data.flip;
                job_reg.total <= cnt_next;
                job_reg.low_x  <= lo_next[0];
                job_reg.low_y  <= lo_next[1];
                job_reg.low_z  <= lo_next[2];
                job_reg.high_x <= hi_next[0];
                job_reg.high_y <= hi_next[1];
                job_reg.high_z <= hi_next[2];
            end
            else if (job_ready)
                job_valid_reg <= 1'b0;
        end
    end

    assign job_valid = job_valid_reg;
    assign job_data  = job_reg;

endmodule

// ----- rtl/tfnb_back.sv -----
// Back end: cross product, shared multiplier, sqrt and divide sequencer.
module tfnb_back
    import tfnb_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] min_length,
    input  logic        job_valid,
    output logic        job_ready,
    input  tri_job_t    job_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tri_out_t    out_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_NORM, S_SQ, S_SQRT, S_DIV, S_DONE
    } state_t;

    // numerator m << FRAC plus half the root needs one bit over 31 + FRAC
    localparam int DW = 32 + NORMAL_FRAC_BITS;

    state_t             state_reg;
    tri_job_t           job_reg;
    logic [3:0]         step_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] cr_reg [3];
    logic [6:0]         shift_reg;
    logic [30:0]        m_reg [3];
    logic [63:0]        sum_reg;
    logic [63:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [5:0]         iter_reg;
    logic [DW-1:0]      num_reg;
    logic [DW:0]        drem_reg;
    logic [DW-1:0]      quo_reg;
    logic [1:0]         axis_reg;
    logic signed [15:0] nrm_reg [3];
    logic               degen_reg;
    logic               out_valid_reg;

    // Multiplier operands per step: even step = first product, odd = second.
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    always_comb
    begin
        case (step_reg[3:1])
            3'd0:    begin ma = job_reg.u_y; mb = step_reg[0] ? job_reg.v_y : job_reg.v_z; end
            3'd1:    begin ma = job_reg.u_z; mb = step_reg[0] ? job_reg.v_z : job_reg.v_x; end
            default: begin ma = job_reg.u_x; mb = step_reg[0] ? job_reg.v_x : job_reg.v_y; end
        endcase
        if (step_reg[0])
        begin
            case (step_reg[3:1])
                3'd0:    ma = job_reg.u_z;
                3'd1:    ma = job_reg.u_x;
                default: ma = job_reg.u_y;
            endcase
        end
        mp = 66'(ma) * 66'(mb);
    end

    // bit length of magnitude of each cross term
    function automatic logic [65:0] mag(input logic signed [65:0] x);
        return x[65] ? 66'(-x) : 66'(x);
    endfunction
    function automatic logic [6:0] blen(input logic [65:0] x);
        logic [6:0] n;
        n = '0;
        for (int k = 0; k < 66; k++)
            if (x[k]) n = 7'(k + 1);
        return n;
    endfunction

    logic [6:0] s_need;
    always_comb
    begin
        logic [6:0] bl;
        s_need = '0;
        for (int i = 0; i < 3; i++)
        begin
            bl = blen(mag(cr_reg[i]));
            if (bl > 7'd31 && bl - 7'd31 > s_need)
                s_need = bl - 7'd31;
        end
    end

    logic [63:0] trial;
    logic [63:0] rem_sh;
    assign rem_sh = {rem_reg[61:0], sum_reg[63:62]};
    assign trial  = {30'd0, root_reg, 2'b01};

    logic [DW:0] dtry;
    assign dtry = {drem_reg[DW-1:0], num_reg[DW-1]};

    logic signed [31:0] qs;
    always_comb
    begin
        logic [DW-1:0] q;
        q  = quo_reg;
        qs = (q > DW'(NORMAL_MAX)) ? 32'(NORMAL_MAX) : 32'(q);
        if (cr_reg[axis_reg][65])
            qs = -qs;
    end

    assign job_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        job_reg   <= job_data;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                S_MUL:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg[0])
                        cr_reg[step_reg[2:1]] <= prod_reg - mp;
                    else
                        prod_reg <= mp;
                    if (step_reg == 4'd5)
                        state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    shift_reg <= s_need;
                    for (int i = 0; i < 3; i++)
                        m_reg[i] <= 31'(mag(cr_reg[i]) >> s_need);
                    sum_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sum_reg  <= sum_reg + 64'(m_reg[step_reg[1:0]]) *
                                          64'(m_reg[step_reg[1:0]]);
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd2)
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    sum_reg  <= {sum_reg[61:0], 2'b00};
                    iter_reg <= iter_reg + 6'd1;
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    if (iter_reg == 6'd31)
                        state_reg <= S_DIV;
                    axis_reg <= '0;
                    step_reg <= '0;
                end
                S_DIV:
                begin
                    if (step_reg == 4'd0)
                    begin
                        degen_reg <= 64'(root_reg) <= (64'(min_length) >> shift_reg);
                        if (64'(root_reg) <= (64'(min_length) >> shift_reg))
                        begin
                            nrm_reg[0] <= '0;
                            nrm_reg[1] <= '0;
                            nrm_reg[2] <= (NORMAL_FRAC_BITS > 14) ? NORMAL_MAX :
                                          16'(1 << NORMAL_FRAC_BITS);
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            num_reg  <= (DW'(m_reg[axis_reg]) << NORMAL_FRAC_BITS)
                                        + DW'(root_reg >> 1);
                            drem_reg <= '0;
                            quo_reg  <= '0;
                            iter_reg <= '0;
                            step_reg <= 4'd1;
                        end
                    end
                    else if (step_reg == 4'd1)
                    begin
                        num_reg  <= {num_reg[DW-2:0], 1'b0};
                        iter_reg <= iter_reg + 6'd1;
                        if (dtry >= (DW+1)'(root_reg))
                        begin
                            drem_reg <= dtry - (DW+1)'(root_reg);
                            quo_reg  <= {quo_reg[DW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= dtry;
                            quo_reg  <= {quo_reg[DW-2:0], 1'b0};
                        end
                        if (iter_reg == 6'(DW - 1))
                            step_reg <= 4'd2;
                    end
                    else if (step_reg == 4'd2)
                    begin
                        nrm_reg[axis_reg] <= 16'(qs);
                        axis_reg <= axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                            state_reg <= S_DONE;
                        else
                            step_reg <= 4'd3;
                    end
                    else
                    begin
                        num_reg  <= (DW'(m_reg[axis_reg]) << NORMAL_FRAC_BITS)
                                    + DW'(root_reg >> 1);
                        drem_reg <= '0;
                        quo_reg  <= '0;
                        iter_reg <= '0;
                        step_reg <= 4'd1;
                    end
                end
                S_DONE:
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data.normal_x <= nrm_reg[0];
                        out_data.normal_y <= nrm_reg[1];
                        out_data.normal_z <= nrm_reg[2];
                        out_data.degenerate <= degen_reg;
                        out_data.swapped <= job_reg.flip;
                        out_data.triangle_total <= job_reg.total;
                        out_data.low_x  <= job_reg.low_x;
                        out_data.low_y  <= job_reg.low_y;
                        out_data.low_z  <= job_reg.low_z;
                        out_data.high_x <= job_reg.high_x;
                        out_data.high_y <= job_reg.high_y;
                        out_data.high_z <= job_reg.high_z;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/triangle_flat_normal_bounds.sv -----
// Top level: triangle face normal with running bounds and count.
//
// channel  | handshake          | payload
// ---------+--------------------+------------------------
// in       | in_valid/in_ready  | in_data  (tri_in_t)
// out      | out_valid/out_ready| out_data (tri_out_t)
// cfg      | cfg_we             | cfg_data (min_length)
//
// The back end runs each word through the bit-serial sqrt and the shared
// restoring divider, whose width is DW = 32+NORMAL_FRAC_BITS; a degenerate
// triangle skips the divider and goes straight to the done state.
// The front register holds one queued word so the next triangle is taken while
// the back end works. Reset clears bounds to empty, count and min_length to zero.
// A stalled output holds its word; the back end then waits in its done state.
module triangle_flat_normal_bounds
    import tfnb_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  tri_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tri_out_t    out_data
);

    logic [31:0] min_length_reg;
    logic        job_valid, job_ready;
    tri_job_t    job_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_length_reg <= '0;
        else if (cfg_we)
            min_length_reg <= cfg_data;
    end

    tfnb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_data,
        .job_valid, .job_ready, .job_data
    );

    tfnb_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
        .clk, .rst_n, .min_length(min_length_reg),
        .job_valid, .job_ready, .job_data,
        .out_valid, .out_ready, .out_data
    );

    // a word handed to the back end leaves the queue empty unless refilled
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready && !(in_valid && in_ready) |=> !job_valid)
        else $error("queue word not consumed");

    // a degenerate result carries zero x and y normal components
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
        out_data.normal_x == 16'sd0 && out_data.normal_y == 16'sd0)
        else $error("degenerate normal wrong");

    // count never exceeds its limit
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.triangle_total <= TRI_LIMIT)
        else $error("count over limit");

endmodule
